// ===== hw/rtl/dq_pkg.sv =====
// Package for the double-ended queue: opcodes, status codes, data width and default depth.
// Used by the top level, the entry RAM and the port checker. No dependencies.
package dq_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Value returned by every push and by a pop that finds nothing.
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE = '1;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
// Top level of the bounded double-ended queue: ring store addressed by head index and count.
// Depends on dq_pkg and dq_ram.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_ready   i_opcode, i_push_value
//   result    out        o_valid / i_ready   o_pop_value, o_status, o_is_empty
//
// One transaction is accepted per cycle while no waiting result is stalled; its result is shown on the next cycle.
// Each item makes at most one access to the single-port entry RAM, which sets the rate.
// Reset clears head index and count; the store itself is not cleared.
// A result waiting on i_ready blocks new requests only if it is not taken that cycle.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_opcode,
    input  logic signed [dq_pkg::DATA_W-1:0]  i_push_value,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [dq_pkg::DATA_W-1:0]  o_pop_value,
    output logic [1:0]                        o_status,
    output logic                              o_is_empty
);
    import dq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;
    logic          r_use_mem, n_use_mem;
    t_status       r_status, n_status;
    logic          r_is_empty;

    logic          accept;
    t_opcode       op;
    logic          is_full, is_zero;
    logic [AW-1:0] head_dec, head_inc, back_pos;
    logic [CW-1:0] back_off;
    logic [AW:0]   back_sum;
    logic          wr_en, rd_en;
    logic [AW-1:0] addr;
    logic [DATA_W-1:0] rd_data;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign op      = t_opcode'(i_opcode);

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_zero  = (r_count == '0);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    // Back position: head plus count for a push, head plus count minus one for a pop.
    assign back_off = (op == OP_POP_BACK) ? r_count - 1'b1 : r_count;
    assign back_sum = (AW + 1)'(r_head) + (AW + 1)'(back_off);
    assign back_pos = (back_sum >= (AW + 1)'(DEPTH)) ? AW'(back_sum - (AW + 1)'(DEPTH))
                                                     : AW'(back_sum);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_status  = ST_OK;
        n_use_mem = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        addr      = back_pos;
        case (op)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                    addr    = head_dec;
                    wr_en   = accept;
                end
            end
            OP_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                    wr_en   = accept;
                end
            end
            OP_POP_FRONT: begin
                if (is_zero) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_head    = head_inc;
                    n_count   = r_count - 1'b1;
                    addr      = r_head;
                    rd_en     = accept;
                    n_use_mem = 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (is_zero) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count   = r_count - 1'b1;
                    rd_en     = accept;
                    n_use_mem = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status   <= n_status;
            r_use_mem  <= n_use_mem;
            r_is_empty <= (n_count == '0);
        end
    end

    dq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_rd_en   (rd_en),
        .i_addr    (addr),
        .i_wr_data (i_push_value),
        .o_rd_data (rd_data)
    );

    assign o_valid     = r_out_valid;
    assign o_pop_value = r_use_mem ? $signed(rd_data) : EMPTY_VALUE;
    assign o_status    = r_status;
    assign o_is_empty  = r_is_empty;

endmodule

// ===== hw/rtl/dq_ram.sv =====
// Single-port entry store for the queue, one access per cycle, registered read data.
// Depends on dq_pkg for the data width.
module dq_ram #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
    parameter int AW    = 4
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_addr,
    input  logic [dq_pkg::DATA_W-1:0]     i_wr_data,
    output logic [dq_pkg::DATA_W-1:0]     o_rd_data
);
    import dq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    // The read register holds its value until the next read, so a waiting
    // result keeps its data without a copy elsewhere.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/dq_checker.sv =====
// Port-level checker for double_ended_queue, attached by the bind at the end of this file.
// Depends on dq_pkg for status codes and the empty value.
module dq_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_o_ready,
    input  logic                              i_o_valid,
    input  logic                              i_ready,
    input  logic signed [dq_pkg::DATA_W-1:0]  i_pop_value,
    input  logic [1:0]                        i_status,
    input  logic                              i_is_empty
);
    import dq_pkg::*;

    // A refused or failed transaction never returns data.
    a_no_data_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_o_valid && i_status != ST_OK) |-> (i_pop_value == EMPTY_VALUE))
        else $error("error status with a data value");

    // A pop that found nothing leaves the queue empty; a refused push leaves it full.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_o_valid && i_status == ST_EMPTY) |-> i_is_empty)
        else $error("empty pop but queue reported non-empty");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_o_valid && i_status == ST_FULL) |-> !i_is_empty)
        else $error("full push but queue reported empty");

    // Each accepted request yields a result on the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_o_ready) |=> i_o_valid)
        else $error("accepted transaction produced no result");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_o_valid && !i_ready) |=> (i_o_valid && $stable(i_pop_value)
                                     && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .i_o_ready   (o_ready),
    .i_o_valid   (o_valid),
    .i_ready     (i_ready),
    .i_pop_value (o_pop_value),
    .i_status    (o_status),
    .i_is_empty  (o_is_empty)
);

// ===== verif/tb_double_ended_queue.sv =====
// Self-checking testbench for double_ended_queue: random and directed deque traffic
// with randomized stalls on both channels, checked against an in-bench ring model.
// Depends on dq_pkg and the double_ended_queue RTL.
`timescale 1ns / 1ps

module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int Q_DEPTH      = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1875;
    localparam int LIMIT_CYCLES = 400000;
    localparam int LONG_HOLD    = 120;
    localparam int HOLD_AT_A    = 400;
    localparam int HOLD_AT_B    = 1400;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        t_opcode            op;
        logic signed [31:0] value;
        int                 gap;
        bit                 drain;
    } t_deque_request;

    typedef struct {
        logic signed [31:0] pop_value;
        t_status            status;
        logic               is_empty;
    } t_deque_result;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic [1:0]         i_opcode     = 2'd0;
    logic signed [31:0] i_push_value = '0;
    logic               i_ready      = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [31:0] o_pop_value;
    logic [1:0]         o_status;
    logic               o_is_empty;

    double_ended_queue dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_is_empty   (o_is_empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Ring model of the deque.
    logic signed [31:0] ring_store [Q_DEPTH];
    int                 ring_head  = 0;
    int                 ring_count = 0;

    t_deque_request pending_q [$];
    t_deque_result  expected_q [$];

    int  cycle_count    = 0;
    int  error_count    = 0;
    int  accepted_count = 0;
    int  results_seen   = 0;
    int  refused_pushes = 0;
    int  empty_pops     = 0;
    int  peak_fill      = 0;
    int  op_seen [4]    = '{0, 0, 0, 0};
    bit  req_taken      = 1'b0;
    bit  rsp_taken      = 1'b0;
    bit  sender_done    = 1'b0;

    function automatic t_deque_result apply_deque_op(t_opcode op, logic signed [31:0] value);
        t_deque_result r;
        int            slot;
        r.pop_value = EMPTY_VALUE;
        r.status    = ST_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (ring_count >= Q_DEPTH) begin
                r.status = ST_FULL;
                refused_pushes++;
            end else begin
                if (op == OP_PUSH_FRONT) begin
                    ring_head = (ring_head + Q_DEPTH - 1) % Q_DEPTH;
                    slot      = ring_head;
                end else begin
                    slot = (ring_head + ring_count) % Q_DEPTH;
                end
                ring_store[slot] = value;
                ring_count++;
                if (ring_count > peak_fill) peak_fill = ring_count;
            end
        end else if (ring_count == 0) begin
            r.status = ST_EMPTY;
            empty_pops++;
        end else if (op == OP_POP_FRONT) begin
            r.pop_value = ring_store[ring_head];
            ring_head   = (ring_head + 1) % Q_DEPTH;
            ring_count--;
        end else begin
            r.pop_value = ring_store[(ring_head + ring_count - 1) % Q_DEPTH];
            ring_count--;
        end
        r.is_empty = (ring_count == 0);
        return r;
    endfunction

    task automatic add_item(t_opcode op, logic signed [31:0] value, int gap);
        t_deque_request req;
        req.op    = op;
        req.value = value;
        req.gap   = gap;
        req.drain = 1'b0;
        pending_q.push_back(req);
    endtask

    // A drain marker makes the sender wait until every outstanding result has arrived.
    task automatic add_pause();
        t_deque_request req;
        req.op    = OP_POP_FRONT;
        req.value = '0;
        req.gap   = 0;
        req.drain = 1'b1;
        pending_q.push_back(req);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return '0;
            4:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    // Sender: one item in flight, each preceded by its own idle gap.
    t_deque_request cur_req;
    bit             have_item = 1'b0;
    bit             draining  = 1'b0;
    int             gap_left  = 0;

    always @(negedge i_clk) begin
        logic nxt_valid;
        nxt_valid = 1'b0;
        if (i_rst_n) begin
            if (req_taken) begin
                have_item = 1'b0;
                req_taken = 1'b0;
            end
            if (draining && expected_q.size() == 0) draining = 1'b0;
            if (!have_item && !draining && pending_q.size() != 0) begin
                cur_req = pending_q.pop_front();
                if (cur_req.drain) begin
                    draining = 1'b1;
                end else begin
                    have_item = 1'b1;
                    gap_left  = cur_req.gap;
                end
            end
            if (have_item) begin
                if (gap_left > 0) gap_left--;
                else nxt_valid = 1'b1;
            end
            if (!have_item && !draining && pending_q.size() == 0) sender_done = 1'b1;
            i_valid      <= nxt_valid;
            i_opcode     <= cur_req.op;
            i_push_value <= cur_req.value;
        end
    end

    // Receiver: random stall after each result, a stall-free window, and two long hold-offs.
    int rx_wait = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_taken) begin
                rsp_taken = 1'b0;
                if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
                    rx_wait = LONG_HOLD;
                else if (results_seen >= 600 && results_seen < 900)
                    rx_wait = 0;
                else
                    rx_wait = $urandom_range(0, 19);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted result.
    always @(posedge i_clk) begin
        t_deque_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                rsp_taken = 1'b1;
                results_seen++;
                if (expected_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: unexpected result value=%0d status=%0d empty=%0b",
                                 o_pop_value, o_status, o_is_empty);
                end else begin
                    want = expected_q.pop_front();
                    if (o_pop_value !== want.pop_value || o_status !== want.status ||
                        o_is_empty !== want.is_empty) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("ERROR: result %0d expected value=%0d status=%0d empty=%0b",
                                     results_seen, want.pop_value, want.status,
                                     want.is_empty);
                            $display("       got value=%0d status=%0d empty=%0b",
                                     o_pop_value, o_status, o_is_empty);
                        end
                    end
                end
            end
            if (i_valid && o_ready) begin
                expected_q.push_back(apply_deque_op(t_opcode'(i_opcode), i_push_value));
                op_seen[i_opcode]++;
                accepted_count++;
                req_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int      n;
        int      seg_len;
        int      push_pct;
        bit      burst;
        t_opcode op;

        // Directed: pops on empty, extremes, front-push wrap, fill to full, refusals.
        add_item(OP_POP_FRONT, 32'sh1234_5678, 0);
        add_item(OP_POP_BACK, -32'sd1, 3);
        add_item(OP_PUSH_FRONT, 32'sh7FFF_FFFF, 0);
        add_item(OP_PUSH_BACK, 32'sh8000_0000, 1);
        add_item(OP_POP_FRONT, '0, 0);
        add_item(OP_POP_BACK, '0, 0);
        for (int k = 0; k < Q_DEPTH; k++)
            add_item((k % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT,
                     (k % 3 == 0) ? 32'sh5555_5555 : (k % 3 == 1) ? 32'shAAAA_AAAA : k, 0);
        add_item(OP_PUSH_FRONT, 32'sh0BAD_F00D, 2);
        add_item(OP_PUSH_BACK, 32'sh0BAD_F00D, 0);
        add_item(OP_POP_FRONT, '0, 0);
        add_item(OP_POP_BACK, '0, 0);
        add_pause();

        // Random walks whose push share varies per segment, so the queue
        // swings between empty and full with both ends in use.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 4))
                0:       push_pct = 10;
                1:       push_pct = 35;
                2:       push_pct = 50;
                3:       push_pct = 65;
                default: push_pct = 90;
            endcase
            burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
                if ($urandom_range(0, 99) < push_pct)
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                add_item(op, pick_value(), burst ? 0 : $urandom_range(0, 19));
                n++;
            end
            if (n >= 1000 && n < 1000 + seg_len) add_pause();
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(sender_done && expected_q.size() == 0)) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d transactions (push front %0d, push back %0d,",
                 accepted_count, op_seen[0], op_seen[1]);
        $display("pop front %0d, pop back %0d), refused pushes %0d, empty pops %0d, peak fill %0d",
                 op_seen[2], op_seen[3], refused_pushes, empty_pops, peak_fill);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
